### src/sliding_window_arq_sender_assert.svh
// Assertion macros for the ARQ sender window control.
`ifndef SLIDING_WINDOW_ARQ_SENDER_ASSERT_SVH
`define SLIDING_WINDOW_ARQ_SENDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SWARQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SWARQ_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SWARQ_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define SWARQ_ASSERT(lbl, expr, msg)
`define SWARQ_ASSERT_IMP(lbl, a, c, msg)
`define SWARQ_ASSERT_NXT(lbl, a, c, msg)
`endif
`endif

### src/swarq_pkg.sv
// Shared constants and types of the ARQ sender window control.
package swarq_pkg;
  localparam int WINDOW_MAX_DEF = 8;
  localparam int SEQ_BITS_DEF   = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int NW             = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_ACK   = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;
  localparam logic [1:0] FUNC_IDLE  = 2'd3;

  localparam logic [1:0] MODE_SNW  = 2'd0;
  localparam logic [1:0] MODE_GBN  = 2'd1;
  localparam logic [1:0] MODE_SR   = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_RETX  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic        eot;
  } res_t;

  typedef struct packed {
    logic push;
    logic flush;
    res_t res;
  } out_ctl_t;
endpackage

### src/swarq_in_if.sv
// Input channel: tick, acknowledgement or buffer start.
interface swarq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] ack_seq;
  logic        ack_is_nak;
  logic        ack_corrupt;
  logic [15:0] frames_in_buffer;
  logic        final_buffer;
  modport source (output valid, func, ack_seq, ack_is_nak, ack_corrupt,
                  frames_in_buffer, final_buffer, input ready);
  modport sink (input valid, func, ack_seq, ack_is_nak, ack_corrupt,
                frames_in_buffer, final_buffer, output ready);
endinterface

### src/swarq_out_if.sv
// Output channel: send commands and buffer completion.
interface swarq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] frame_seq;
  logic        end_of_transfer;
  logic        last;
  modport source (output valid, kind, frame_seq, end_of_transfer, last, input ready);
  modport sink (input valid, kind, frame_seq, end_of_transfer, last, output ready);
endinterface

### src/swarq_tmem.sv
// Send-time memory, one write and one registered read port.
module swarq_tmem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/swarq_out.sv
// Result holding stage and output register; marks the last result of a transaction.
module swarq_out
  import swarq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  out_ctl_t   ctl,
  output logic       can_take,
  output logic       pend_busy,
  swarq_out_if.source o
);
  res_t pend;
  logic pend_v;
  logic out_free;

  assign out_free  = !o.valid || o.ready;
  assign can_take  = !pend_v || out_free;
  assign pend_busy = pend_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v  <= 1'b0;
      o.valid <= 1'b0;
    end else begin
      if (ctl.push && can_take) begin
        if (pend_v) begin
          o.valid           <= 1'b1;
          o.kind            <= pend.kind;
          o.frame_seq       <= pend.seq;
          o.end_of_transfer <= pend.eot;
          o.last            <= 1'b0;
        end else if (o.valid && o.ready) begin
          o.valid <= 1'b0;
        end
        pend   <= ctl.res;
        pend_v <= 1'b1;
      end else if (ctl.flush && pend_v && out_free) begin
        o.valid           <= 1'b1;
        o.kind            <= pend.kind;
        o.frame_seq       <= pend.seq;
        o.end_of_transfer <= pend.eot;
        o.last            <= 1'b1;
        pend_v            <= 1'b0;
      end else if (o.valid && o.ready) begin
        o.valid <= 1'b0;
      end
    end
  end
endmodule

### src/sliding_window_arq_sender.sv
// Top level: window control sequencer of the ARQ sender.
// One transaction is taken at a time. After it is accepted the window slides over acked
// slots, then the first-send pass walks the window slot by slot, then the retransmit pass
// reads each slot's send time from the memory and then checks it, or in go-back-N reads and
// checks the head slot once and then resends slot by slot; each pass then sees its end, and
// finishing waits while the output is stalled. Results leave one per cycle, while the output
// is not stalled, through a holding stage and an output register. Slot flags sit in
// flip-flops; send times in a small memory addressed circularly from the window head.
`include "sliding_window_arq_sender_assert.svh"
module sliding_window_arq_sender
  import swarq_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  swarq_in_if.sink    in_ch,
  swarq_out_if.source out_ch
);
  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SLIDE   = 9'b000000010,
    S_FIRST   = 9'b000000100,
    S_SR_RD   = 9'b000001000,
    S_SR_CHK  = 9'b000010000,
    S_GB_RD   = 9'b000100000,
    S_GB_CHK  = 9'b001000000,
    S_GB_SEND = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state;
  logic [1:0]  arq_mode;
  logic [3:0]  window_slots;
  logic [15:0] timeout_ticks;
  logic [SEQ_BITS-1:0] base, total;
  logic fin, done_buf;
  logic [31:0] now;
  logic [WINDOW_MAX-1:0] acked, sent, forced;
  logic [IW-1:0] head;
  logic [CW-1:0] w, i, w_act;
  logic [NW-1:0] n;

  out_ctl_t ctl;
  logic can_take, pend_busy;
  logic [31:0] t_rd;
  logic mem_we;
  logic [IW-1:0] p_i, p_ack;

  logic [SEQ_BITS-1:0] seq_in;
  logic [SEQ_BITS:0]   ack_diff, seq_i;
  logic ack_hit, lt, room, timed, do_send;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] k);
    int p;
    p = int'(h) + int'(k);
    if (p >= WINDOW_MAX) p = p - WINDOW_MAX;
    return IW'(p);
  endfunction

  always_comb begin
    if (arq_mode == MODE_SNW || window_slots == 4'd0) w_act = CW'(1);
    else if (int'(window_slots) > WINDOW_MAX) w_act = CW'(WINDOW_MAX);
    else w_act = CW'(window_slots);
  end

  assign seq_in   = SEQ_BITS'(in_ch.ack_seq);
  assign ack_diff = {1'b0, seq_in} - {1'b0, base};
  assign ack_hit  = !in_ch.ack_corrupt && !done_buf && (seq_in >= base) &&
                    (ack_diff < (SEQ_BITS + 1)'(w_act)) && (seq_in < total);
  assign p_ack    = phys(head, CW'(ack_diff));
  assign p_i      = phys(head, i);
  assign seq_i    = {1'b0, base} + (SEQ_BITS + 1)'(i);
  assign lt       = seq_i < {1'b0, total};
  assign room     = n < NW'(MAX_RESULTS);
  assign timed    = forced[p_i] || ((now - t_rd) > {16'd0, timeout_ticks});
  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    ctl          = '0;
    ctl.flush    = (state == S_DONE);
    ctl.res.seq  = 16'(seq_i[SEQ_BITS-1:0]);
    ctl.res.eot  = fin && ((seq_i + 1'b1) == {1'b0, total});
    ctl.res.kind = (state == S_FIRST) ? KIND_FIRST : KIND_RETX;
    case (state)
      S_SLIDE: begin
        if (!(i < w && acked[head]) && base >= total) begin
          ctl.push     = 1'b1;
          ctl.res.kind = KIND_DONE;
          ctl.res.seq  = 16'd0;
          ctl.res.eot  = fin;
        end
      end
      S_FIRST:   ctl.push = (i != w) && lt && !sent[p_i] && room;
      S_SR_CHK:  ctl.push = lt && sent[p_i] && !acked[p_i] && timed && room;
      S_GB_SEND: ctl.push = (i != w) && lt && room;
      default:   ctl.push = 1'b0;
    endcase
  end

  assign do_send = ctl.push && can_take && (state != S_SLIDE);
  assign mem_we  = do_send;

  swarq_tmem #(.DEPTH(WINDOW_MAX), .AW(IW)) u_tmem (
    .clk(clk), .we(mem_we), .waddr(p_i), .wdata(now), .raddr(p_i), .rdata(t_rd)
  );

  swarq_out u_out (
    .clk(clk), .rst(rst), .ctl(ctl), .can_take(can_take), .pend_busy(pend_busy), .o(out_ch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      arq_mode      <= MODE_SR;
      window_slots  <= 4'd8;
      timeout_ticks <= 16'd10;
      base          <= '0;
      total         <= '0;
      fin           <= 1'b0;
      done_buf      <= 1'b1;
      now           <= '0;
      acked         <= '0;
      sent          <= '0;
      forced        <= '0;
      head          <= '0;
      w             <= '0;
      i             <= '0;
      n             <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:    arq_mode      <= cfg_data[1:0];
          REG_WINDOW:  window_slots  <= cfg_data[3:0];
          REG_TIMEOUT: timeout_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (do_send) begin
        sent[p_i]   <= 1'b1;
        forced[p_i] <= 1'b0;
        n           <= n + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            w <= w_act;
            i <= '0;
            n <= '0;
            state <= (done_buf && in_ch.func != FUNC_START) ? S_DONE : S_SLIDE;
            case (in_ch.func)
              FUNC_TICK: now <= now + 32'd1;
              FUNC_ACK: begin
                if (ack_hit) begin
                  if (in_ch.ack_is_nak) forced[p_ack] <= 1'b1;
                  else acked[p_ack] <= 1'b1;
                end
              end
              FUNC_START: begin
                total    <= SEQ_BITS'(in_ch.frames_in_buffer);
                fin      <= in_ch.final_buffer;
                base     <= '0;
                done_buf <= 1'b0;
                acked    <= '0;
                sent     <= '0;
                forced   <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SLIDE: begin
          if (i < w && acked[head]) begin
            acked[head]  <= 1'b0;
            sent[head]   <= 1'b0;
            forced[head] <= 1'b0;
            head         <= phys(head, CW'(1));
            base         <= base + 1'b1;
            i            <= i + 1'b1;
          end else if (base >= total) begin
            if (can_take) begin
              done_buf <= 1'b1;
              n        <= n + 1'b1;
              state    <= S_DONE;
            end
          end else begin
            i     <= '0;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (i == w) begin
            i     <= '0;
            state <= (arq_mode == MODE_GBN) ? S_GB_RD : S_SR_RD;
          end else if (!ctl.push || can_take) begin
            i <= i + 1'b1;
          end
        end
        S_SR_RD: state <= (i == w) ? S_DONE : S_SR_CHK;
        S_SR_CHK: begin
          if (!ctl.push || can_take) begin
            i     <= i + 1'b1;
            state <= S_SR_RD;
          end
        end
        S_GB_RD: state <= S_GB_CHK;
        S_GB_CHK: state <= (sent[head] && !acked[head] && timed) ? S_GB_SEND : S_DONE;
        S_GB_SEND: begin
          if (i == w) state <= S_DONE;
          else if (!ctl.push || can_take) i <= i + 1'b1;
        end
        S_DONE: if (!pend_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `SWARQ_ASSERT_IMP(a_idle_flushed, in_ch.ready, !pend_busy, "idle with a result held back")
  `SWARQ_ASSERT(a_result_limit, n <= NW'(MAX_RESULTS), "result limit exceeded")
  `SWARQ_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
                    "ready right after a transaction")
  `SWARQ_ASSERT_IMP(a_no_send_when_done, do_send, !done_buf, "send with no buffer active")
endmodule

### tb/sv/tb.sv
// Testbench for the ARQ sender window control: directed and random transactions, predicted.
module tb;
  import swarq_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic        eot;
    logic        last;
  } send_cmd_t;

  logic clk;
  logic rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  swarq_in_if  in_ch ();
  swarq_out_if out_ch ();

  sliding_window_arq_sender dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  logic [1:0]  m_mode;
  logic [3:0]  m_wslots;
  logic [15:0] m_tmo;
  logic [31:0] m_base;
  logic [31:0] m_total;
  logic        m_final;
  logic        m_complete;
  logic [31:0] m_now;
  logic        m_acked [8];
  logic        m_sent [8];
  logic        m_forced [8];
  logic [31:0] m_stime [8];

  send_cmd_t cmd_q[$];
  int errors = 0;
  int n_items = 0;
  int n_cmds = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

  function automatic int win_now();
    if (m_mode == MODE_SNW) return 1;
    if (m_wslots == 0) return 1;
    if (m_wslots > 8) return 8;
    return int'(m_wslots);
  endfunction

  function automatic void clear_marks();
    for (int i = 0; i < 8; i++) begin
      m_acked[i] = 1'b0;
      m_sent[i] = 1'b0;
      m_forced[i] = 1'b0;
      m_stime[i] = '0;
    end
  endfunction

  function automatic bit is_due(int i);
    logic [31:0] el;
    el = m_now - m_stime[i];
    return m_forced[i] || (el > {16'd0, m_tmo});
  endfunction

  function automatic void issue(int i, logic [1:0] k, ref int n);
    send_cmd_t c;
    logic [31:0] s;
    s = m_base + i;
    c.kind = k;
    c.seq = s[15:0];
    c.eot = m_final && (s + 1 == m_total);
    c.last = 1'b0;
    cmd_q.push_back(c);
    n++;
    m_sent[i] = 1'b1;
    m_forced[i] = 1'b0;
    m_stime[i] = m_now;
  endfunction

  function automatic void predict(logic [1:0] f, logic [15:0] aseq, logic nak, logic bad,
                                  logic [15:0] frames, logic fin);
    int w;
    int n;
    int sh;
    send_cmd_t c;
    w = win_now();
    n = 0;
    if (f == FUNC_TICK) begin
      m_now = m_now + 1;
    end else if (f == FUNC_ACK) begin
      if (!bad && !m_complete && {16'd0, aseq} >= m_base &&
          ({16'd0, aseq} - m_base) < w && {16'd0, aseq} < m_total) begin
        if (nak) m_forced[aseq - m_base] = 1'b1;
        else m_acked[aseq - m_base] = 1'b1;
      end
    end else if (f == FUNC_START) begin
      m_total = {16'd0, frames};
      m_final = fin;
      m_base = '0;
      m_complete = 1'b0;
      clear_marks();
    end
    if (!m_complete) begin
      sh = 0;
      while (sh < w && m_acked[sh]) sh++;
      if (sh > 0) begin
        for (int i = 0; i < 8; i++) begin
          m_acked[i] = (i + sh < 8) ? m_acked[i + sh] : 1'b0;
          m_sent[i] = (i + sh < 8) ? m_sent[i + sh] : 1'b0;
          m_forced[i] = (i + sh < 8) ? m_forced[i + sh] : 1'b0;
          m_stime[i] = (i + sh < 8) ? m_stime[i + sh] : '0;
        end
        m_base = m_base + sh;
      end
      if (m_base >= m_total) begin
        m_complete = 1'b1;
        c.kind = KIND_DONE;
        c.seq = '0;
        c.eot = m_final;
        c.last = 1'b0;
        cmd_q.push_back(c);
        n++;
      end else begin
        for (int i = 0; i < w; i++)
          if (m_base + i < m_total && !m_sent[i] && n < MAX_RESULTS) issue(i, KIND_FIRST, n);
        if (m_mode == MODE_GBN) begin
          if (m_sent[0] && !m_acked[0] && is_due(0))
            for (int i = 0; i < w; i++)
              if (m_base + i < m_total && n < MAX_RESULTS) issue(i, KIND_RETX, n);
        end else begin
          for (int i = 0; i < w; i++)
            if (m_base + i < m_total && m_sent[i] && !m_acked[i] && is_due(i) &&
                n < MAX_RESULTS)
              issue(i, KIND_RETX, n);
        end
      end
    end
    if (n > 0) cmd_q[cmd_q.size() - 1].last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      send_cmd_t e;
      if (cmd_q.size() == 0) begin
        $error("unexpected result kind=%0d seq=%0d", out_ch.kind, out_ch.frame_seq);
        errors++;
      end else begin
        e = cmd_q.pop_front();
        n_cmds++;
        if (out_ch.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.frame_seq !== e.seq) begin
          $error("frame_seq: expected %0d, got %0d", e.seq, out_ch.frame_seq);
          errors++;
        end
        if (out_ch.end_of_transfer !== e.eot) begin
          $error("end_of_transfer: expected %0d, got %0d", e.eot, out_ch.end_of_transfer);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // receiver
  initial begin
    int k;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      k = idle_on ? $urandom_range(0, 17) : 0;
      if (k > 0) begin
        out_ch.ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(logic [1:0] f, logic [15:0] aseq, logic nak, logic bad,
                           logic [15:0] frames, logic fin);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.ack_seq <= aseq;
    in_ch.ack_is_nak <= nak;
    in_ch.ack_corrupt <= bad;
    in_ch.frames_in_buffer <= frames;
    in_ch.final_buffer <= fin;
    do @(posedge clk); while (!in_ch.ready);
    predict(f, aseq, nak, bad, frames, fin);
    n_items++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) m_mode = val[1:0];
    else if (idx == REG_WINDOW) m_wslots = val[3:0];
    else if (idx == REG_TIMEOUT) m_tmo = val;
  endtask

  task automatic rand_item();
    int r;
    logic [1:0]  f;
    logic [15:0] aseq;
    logic        nak;
    logic        bad;
    logic [15:0] frames;
    logic        fin;
    r = $urandom_range(0, 99);
    aseq = 16'($urandom);
    nak = $urandom_range(0, 99) < 15;
    bad = $urandom_range(0, 99) < 10;
    fin = 1'($urandom);
    r = $urandom_range(0, 99);
    frames = 16'((r < 80) ? $urandom_range(0, 12) :
                 (r < 92) ? $urandom_range(13, 40) : $urandom);
    r = $urandom_range(0, 99);
    if (r < 5 || (m_complete && r < 60)) f = FUNC_START;
    else if (r < 40) f = FUNC_TICK;
    else if (r < 96) begin
      f = FUNC_ACK;
      if ($urandom_range(0, 99) < 85)
        aseq = 16'(m_base + $urandom_range(0, win_now() - 1));
    end else f = FUNC_IDLE;
    send_item(f, aseq, nak, bad, frames, fin);
  endtask

  task automatic test_directed();
    send_item(FUNC_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_ACK, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_IDLE, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1);
    send_item(FUNC_START, 16'd0, 1'b0, 1'b0, 16'd0, 1'b1);
    send_item(FUNC_START, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_START, 16'd0, 1'b0, 1'b0, 16'd3, 1'b1);
    send_item(FUNC_ACK, 16'd2, 1'b1, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_ACK, 16'd1, 1'b0, 1'b1, 16'd0, 1'b0);
    send_item(FUNC_ACK, 16'hFFFF, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_ACK, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_ACK, 16'd1, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_ACK, 16'd2, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_START, 16'd0, 1'b0, 1'b0, 16'hFFFF, 1'b0);
    send_item(FUNC_START, 16'd0, 1'b0, 1'b0, 16'd4, 1'b0);
    send_item(FUNC_ACK, 16'd3, 1'b0, 1'b0, 16'd0, 1'b0);
    repeat (11) send_item(FUNC_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0);
    cfg_write(REG_TIMEOUT, 16'd0);
    send_item(FUNC_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item(FUNC_ACK, 16'd4, 1'b0, 1'b0, 16'd0, 1'b0);
  endtask

  task automatic test_mode(logic [1:0] mode, logic [15:0] wsl, logic [15:0] tmo, int n);
    cfg_write(REG_MODE, {14'd0, mode});
    cfg_write(REG_WINDOW, wsl);
    cfg_write(REG_TIMEOUT, tmo);
    send_item(FUNC_START, 16'($urandom), 1'b0, 1'b0, 16'd20, 1'b1);
    repeat (n) rand_item();
  endtask

  task automatic test_backpressure();
    cfg_write(REG_MODE, {14'd0, MODE_GBN});
    cfg_write(REG_WINDOW, 16'd8);
    cfg_write(REG_TIMEOUT, 16'd0);
    idle_on = 1'b0;
    hold_cycles = 600;
    send_item(FUNC_START, 16'd0, 1'b0, 1'b0, 16'd30, 1'b0);
    repeat (30) send_item(FUNC_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0);
    drain();
    idle_on = 1'b1;
    repeat (20) rand_item();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_TICK;
    in_ch.ack_seq <= '0;
    in_ch.ack_is_nak <= 1'b0;
    in_ch.ack_corrupt <= 1'b0;
    in_ch.frames_in_buffer <= '0;
    in_ch.final_buffer <= 1'b0;
    m_mode = MODE_SR;
    m_wslots = 4'd8;
    m_tmo = 16'd10;
    m_base = '0;
    m_total = '0;
    m_final = 1'b0;
    m_complete = 1'b1;
    m_now = '0;
    clear_marks();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_mode(MODE_SNW, 16'd1, 16'd5, 60);
    test_mode(MODE_GBN, 16'd8, 16'd3, 60);
    test_mode(MODE_GBN, 16'd3, 16'd12, 50);
    test_mode(MODE_SR, 16'd8, 16'hFFFF, 50);
    test_mode(MODE_RSVD, 16'd0, 16'd7, 50);
    test_mode(MODE_SR, 16'd15, 16'd20, 60);
    test_backpressure();
    drain();
    $display("Ran %0d input transactions across all modes, window and timeout extremes;",
             n_items);
    $display("checked %0d send and completion results, including a long output stall.", n_cmds);
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
